/* rtl/core/bgs_pkg.sv */
// shared types and constants for the bmp24 grayscale stream core
// used by bgs_luma, bgs_parse and bmp24_grayscale_stream_core; no dependencies
`default_nettype none

package bgs_pkg;

	// build bounds on image size
	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;

	// header layout: bytes 0..33 are parsed, fields are little-endian
	localparam int unsigned HEADER_BYTES = 34;
	localparam int unsigned OFFSET_POS   = 10;
	localparam int unsigned WIDTH_POS    = 18;
	localparam int unsigned HEIGHT_POS   = 22;

	// luma weights, 8 fractional bits
	localparam int unsigned LUMA_R = 77;
	localparam int unsigned LUMA_G = 150;
	localparam int unsigned LUMA_B = 29;

	// field widths
	localparam int unsigned DIM_W   = 13;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned OUT_DW  = 96;

	// result kinds
	localparam logic RK_HEADER = 1'b0;
	localparam logic RK_PIXEL  = 1'b1;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_SKIP   = 2'd1,
		PH_PIXELS = 2'd2,
		PH_IDLE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic               last_pixel;
		logic [COORD_W-1:0] dest_col;
		logic [COORD_W-1:0] dest_row;
		logic [7:0]         gray;
		logic               too_large;
		logic [31:0]        pixel_offset;
		logic [DIM_W-1:0]   image_height;
		logic [DIM_W-1:0]   image_width;
		logic               result_kind;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/bmp24_grayscale_stream_core.sv */
// Streaming 24-bit BMP to 8-bit grayscale core. Takes one file byte per beat,
// emits one header beat after byte 33 and one pixel beat per BGR triple, with
// gray = (77R+150G+29B)>>8, top-down row and column. The core accepts one byte
// every cycle while s_tready is high; the parse logic sits between an input
// register and an output register, which hold the beats in flight. The rate
// is set by the parse state update in bgs_parse, and s_tready drops only when
// both registers are full and m_tready is low.
// depends on bgs_pkg and bgs_parse
`default_nettype none

module bmp24_grayscale_stream_core
	import bgs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,  // file_byte [7:0]
	input  wire logic              s_tuser,  // start_of_file
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_DW-1:0]      m_tdata,  // image_width [12:0], image_height [25:13],
	                                         // pixel_offset [57:26], too_large [58],
	                                         // gray [66:59], dest_row [78:67],
	                                         // dest_col [90:79], zero [95:91]
	output logic                   m_tuser,  // result_kind
	output logic                   m_tlast   // last_pixel
);

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;
	logic       vld_s2;
	result_t    res_s2;
	logic       adv, step, res_valid;
	result_t    res;

	// the output register frees up when empty or taken this cycle
	assign adv      = !vld_s2 || m_tready;
	assign step     = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			sof_s1  <= s_tuser;
		end
	end

	bgs_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.file_byte     (byte_s1),
		.start_of_file (sof_s1),
		.res_valid     (res_valid),
		.res           (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid)
			res_s2 <= res;
	end

	// pack the result beat
	assign m_tvalid = vld_s2;
	assign m_tuser  = res_s2.result_kind;
	assign m_tlast  = res_s2.last_pixel;
	assign m_tdata  = {5'd0, res_s2.dest_col, res_s2.dest_row, res_s2.gray, res_s2.too_large,
		res_s2.pixel_offset, res_s2.image_height, res_s2.image_width};

	// last pixel only on pixel beats
	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == RK_PIXEL)
		else $error("last pixel flag on a header beat");

	// pixel beats never flag an oversize image
	a_pixel_not_large: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == RK_PIXEL |-> !m_tdata[58])
		else $error("too_large set on a pixel beat");

	// column stays inside the parsed width
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == RK_PIXEL |-> {1'b0, m_tdata[90:79]} < m_tdata[12:0])
		else $error("pixel column beyond image width");

	// an empty output register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

endmodule

`default_nettype wire

/* rtl/core/bgs_luma.sv */
// bt601 luma from one bgr triple, fixed point with 8 fractional bits
// depends on bgs_pkg for the weights
`default_nettype none

module bgs_luma
	import bgs_pkg::*;
(
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic      [7:0] gray
);

	logic [15:0] sum;

	// weighted sum fits 16 bits, keep the integer part
	always_comb begin
		sum = 16'(LUMA_R) * {8'd0, red} + 16'(LUMA_G) * {8'd0, green}
			+ 16'(LUMA_B) * {8'd0, blue};
		gray = sum[15:8];
	end

endmodule

`default_nettype wire

/* rtl/core/bgs_parse.sv */
// bmp parse state: header fields, offset skip, pixel triples and row padding
// depends on bgs_pkg and bgs_luma
`default_nettype none

module bgs_parse
	import bgs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] file_byte,
	input  wire logic       start_of_file,
	output logic            res_valid,
	output result_t         res
);

	phase_t             phase_q, phase_c, phase_n;
	logic [31:0]        pos_q, pos_c, pos_n, pos_inc;
	logic [31:0]        width_q, width_c, width_n;
	logic [31:0]        height_q, height_c, height_n;
	logic [31:0]        offset_q, offset_c, offset_n;
	logic [COORD_W-1:0] col_q, col_c, col_n;
	logic [COORD_W-1:0] row_q, row_c, row_n;
	logic [1:0]         tri_q, tri_c, tri_n;
	logic [7:0]         blue_q, blue_c, blue_n;
	logic [7:0]         green_q, green_c, green_n;
	logic [1:0]         pad_q, pad_c, pad_n;
	logic               hdr_done, hdr_big, hdr_stop, pix_out, col_wrap, row_wrap;
	logic [COORD_W:0]   col_inc, row_inc;
	logic [1:0]         lane;
	logic [7:0]         gray;

	// start of file drops all progress before the beat is parsed
	always_comb begin
		if (start_of_file) begin
			phase_c  = PH_HEADER;
			pos_c    = '0;
			width_c  = '0;
			height_c = '0;
			offset_c = '0;
			col_c    = '0;
			row_c    = '0;
			tri_c    = '0;
			blue_c   = '0;
			green_c  = '0;
			pad_c    = '0;
		end else begin
			phase_c  = phase_q;
			pos_c    = pos_q;
			width_c  = width_q;
			height_c = height_q;
			offset_c = offset_q;
			col_c    = col_q;
			row_c    = row_q;
			tri_c    = tri_q;
			blue_c   = blue_q;
			green_c  = green_q;
			pad_c    = pad_q;
		end
	end

	// shared conditions
	assign pos_inc  = pos_c + 32'd1;
	assign hdr_done = (phase_c == PH_HEADER) && (pos_inc >= 32'(HEADER_BYTES));
	assign hdr_big  = (width_c > 32'(MAX_WIDTH)) || (height_c > 32'(MAX_HEIGHT));
	assign hdr_stop = hdr_big || (width_c == 32'd0) || (height_c == 32'd0);
	assign pix_out  = (phase_c == PH_PIXELS) && (pad_c == 2'd0) && (tri_c == 2'd2);
	assign col_inc  = {1'b0, col_c} + 13'd1;
	assign row_inc  = {1'b0, row_c} + 13'd1;
	assign col_wrap = 32'(col_inc) >= width_c;
	assign row_wrap = 32'(row_inc) >= height_c;

	bgs_luma u_luma (
		.red   (file_byte),
		.green (green_c),
		.blue  (blue_c),
		.gray  (gray)
	);

	// next parse phase
	always_comb begin
		phase_n = phase_c;
		unique case (phase_c)
			PH_HEADER: begin
				if (hdr_done) begin
					if (hdr_stop)
						phase_n = PH_IDLE;
					else if (offset_c > 32'(HEADER_BYTES))
						phase_n = PH_SKIP;
					else
						phase_n = PH_PIXELS;
				end
			end
			PH_SKIP: begin
				if (pos_inc >= offset_c)
					phase_n = PH_PIXELS;
			end
			PH_PIXELS: begin
				if (pix_out && col_wrap && row_wrap)
					phase_n = PH_IDLE;
			end
			PH_IDLE: begin
				phase_n = PH_IDLE;
			end
			default: phase_n = PH_IDLE;
		endcase
	end

	// header field capture, counters and held color bytes
	always_comb begin
		pos_n    = pos_c;
		width_n  = width_c;
		height_n = height_c;
		offset_n = offset_c;
		col_n    = col_c;
		row_n    = row_c;
		tri_n    = tri_c;
		blue_n   = blue_c;
		green_n  = green_c;
		pad_n    = pad_c;
		lane     = 2'(pos_c - 32'(OFFSET_POS));
		unique case (phase_c)
			PH_HEADER: begin
				pos_n = pos_inc;
				if (pos_c >= 32'(OFFSET_POS) && pos_c < 32'(OFFSET_POS + 4)) begin
					lane = 2'(pos_c - 32'(OFFSET_POS));
					offset_n[8*lane +: 8] = file_byte;
				end else if (pos_c >= 32'(WIDTH_POS) && pos_c < 32'(WIDTH_POS + 4)) begin
					lane = 2'(pos_c - 32'(WIDTH_POS));
					width_n[8*lane +: 8] = file_byte;
				end else if (pos_c >= 32'(HEIGHT_POS) && pos_c < 32'(HEIGHT_POS + 4)) begin
					lane = 2'(pos_c - 32'(HEIGHT_POS));
					height_n[8*lane +: 8] = file_byte;
				end
				if (hdr_done) begin
					col_n = '0;
					row_n = '0;
					tri_n = '0;
					pad_n = '0;
				end
			end
			PH_SKIP: begin
				pos_n = pos_inc;
			end
			PH_PIXELS: begin
				if (pad_c != 2'd0) begin
					pad_n = pad_c - 2'd1;
				end else if (tri_c == 2'd0) begin
					blue_n = file_byte;
					tri_n  = 2'd1;
				end else if (tri_c == 2'd1) begin
					green_n = file_byte;
					tri_n   = 2'd2;
				end else begin
					tri_n = 2'd0;
					col_n = col_inc[COORD_W-1:0];
					if (col_wrap) begin
						col_n = '0;
						row_n = row_inc[COORD_W-1:0];
						pad_n = width_c[1:0];
						if (row_wrap)
							pad_n = '0;
					end
				end
			end
			PH_IDLE: begin
				pos_n = pos_c;
			end
			default: pos_n = pos_c;
		endcase
	end

	// result for this beat
	always_comb begin
		res_valid        = hdr_done || pix_out;
		res.result_kind  = pix_out ? RK_PIXEL : RK_HEADER;
		res.image_width  = (width_c > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
			: width_c[DIM_W-1:0];
		res.image_height = (height_c > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
			: height_c[DIM_W-1:0];
		res.pixel_offset = offset_c;
		res.too_large    = hdr_done && hdr_big;
		res.gray         = pix_out ? gray : 8'd0;
		res.dest_row     = pix_out ? (height_c[COORD_W-1:0] - COORD_W'(1) - row_c) : '0;
		res.dest_col     = pix_out ? col_c : '0;
		res.last_pixel   = pix_out && col_wrap && row_wrap;
	end

	// parse state registers, advance once per parsed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			offset_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			tri_q    <= '0;
			blue_q   <= '0;
			green_q  <= '0;
			pad_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			width_q  <= width_n;
			height_q <= height_n;
			offset_q <= offset_n;
			col_q    <= col_n;
			row_q    <= row_n;
			tri_q    <= tri_n;
			blue_q   <= blue_n;
			green_q  <= green_n;
			pad_q    <= pad_n;
		end
	end

endmodule

`default_nettype wire

/* test/tb.sv */
// testbench for bmp24_grayscale_stream_core: streams generated 24-bit BMP files byte by byte
// and checks every header and pixel beat against a scoreboard that predicts them
// depends on bgs_pkg and the core RTL
`timescale 1ns / 1ps

module tb;
	import bgs_pkg::*;

	// pixel byte content styles
	localparam int PIX_RANDOM  = 0;
	localparam int PIX_ONES    = 1;
	localparam int PIX_EXTREME = 2;

	// idle patterns for source gaps and sink stalls
	localparam int IDLE_NONE  = 0;
	localparam int IDLE_LIGHT = 1;
	localparam int IDLE_HEAVY = 2;

	localparam int RANDOM_BYTES = 650;

	// one expected output beat
	typedef struct {
		logic               kind;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [31:0]        offset;
		logic               big;
		logic [7:0]         gray;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
	} gray_beat_t;

	// parse state tracker and queue of predicted beats
	class bmp_gray_scoreboard;
		gray_beat_t  expected_beats[$];
		int          n_bytes;
		int          n_headers;
		int          n_pixels;
		int          n_errors;
		logic [31:0] pos;
		phase_t      phase;
		logic [31:0] wid;
		logic [31:0] hgt;
		logic [31:0] ofs;
		logic [12:0] col;
		logic [12:0] row;
		logic [1:0]  tri_idx;
		logic [7:0]  blu;
		logic [7:0]  grn;
		logic [1:0]  pad;

		function void clear();
			pos = 0;
			phase = PH_HEADER;
			wid = 0;
			hgt = 0;
			ofs = 0;
			col = 0;
			row = 0;
			tri_idx = 0;
			blu = 0;
			grn = 0;
			pad = 0;
		endfunction

		function gray_beat_t beat_base(logic kind);
			gray_beat_t e;
			e.kind = kind;
			e.width = (wid > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : wid[DIM_W-1:0];
			e.height = (hgt > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : hgt[DIM_W-1:0];
			e.offset = ofs;
			e.big = 1'b0;
			e.gray = 0;
			e.row = 0;
			e.col = 0;
			e.last = 1'b0;
			return e;
		endfunction

		// advance the parse by one accepted byte
		function void note_file_byte(logic [7:0] b, logic sof);
			gray_beat_t e;
			int unsigned p;
			n_bytes++;
			if (sof)
				clear();
			case (phase)
				PH_HEADER: begin
					p = pos;
					if (p >= OFFSET_POS && p < OFFSET_POS + 4)
						ofs = ofs | (32'(b) << (8 * (p - OFFSET_POS)));
					else if (p >= WIDTH_POS && p < WIDTH_POS + 4)
						wid = wid | (32'(b) << (8 * (p - WIDTH_POS)));
					else if (p >= HEIGHT_POS && p < HEIGHT_POS + 4)
						hgt = hgt | (32'(b) << (8 * (p - HEIGHT_POS)));
					pos = pos + 1;
					if (pos >= HEADER_BYTES) begin
						e = beat_base(RK_HEADER);
						e.big = (wid > MAX_WIDTH) || (hgt > MAX_HEIGHT);
						expected_beats.push_back(e);
						col = 0;
						row = 0;
						tri_idx = 0;
						pad = 0;
						if (e.big || wid == 0 || hgt == 0)
							phase = PH_IDLE;
						else if (ofs > HEADER_BYTES)
							phase = PH_SKIP;
						else
							phase = PH_PIXELS;
					end
				end
				PH_SKIP: begin
					pos = pos + 1;
					if (pos >= ofs)
						phase = PH_PIXELS;
				end
				PH_PIXELS: begin
					if (pad != 0) begin
						pad = pad - 1;
					end else if (tri_idx == 0) begin
						blu = b;
						tri_idx = 1;
					end else if (tri_idx == 1) begin
						grn = b;
						tri_idx = 2;
					end else begin
						tri_idx = 0;
						e = beat_base(RK_PIXEL);
						e.gray = 8'((LUMA_R * b + LUMA_G * grn + LUMA_B * blu) >> 8);
						e.row = COORD_W'(hgt - 1 - 32'(row));
						e.col = col[COORD_W-1:0];
						col = col + 1;
						if (32'(col) >= wid) begin
							col = 0;
							row = row + 1;
							pad = wid[1:0];
							if (32'(row) >= hgt) begin
								e.last = 1'b1;
								phase = PH_IDLE;
								pad = 0;
							end
						end
						expected_beats.push_back(e);
					end
				end
				default: ;
			endcase
		endfunction

		function void same(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				n_errors++;
				if (n_errors <= 40)
					$display("%0t ns: %s mismatch, expected %0h, actual %0h",
						$time, name, want, got);
			end
		endfunction

		// compare one output beat with the oldest prediction
		function void check_gray_beat(logic [OUT_DW-1:0] d, logic kind, logic last);
			gray_beat_t e;
			if (expected_beats.size() == 0) begin
				n_errors++;
				if (n_errors <= 40)
					$display("%0t ns: unexpected beat, expected none, actual kind %0b data %0h",
						$time, kind, d);
				return;
			end
			e = expected_beats.pop_front();
			same("result_kind", e.kind, kind);
			same("image_width", e.width, d[12:0]);
			same("image_height", e.height, d[25:13]);
			same("pixel_offset", e.offset, d[57:26]);
			same("too_large", e.big, d[58]);
			same("gray", e.gray, d[66:59]);
			same("dest_row", e.row, d[78:67]);
			same("dest_col", e.col, d[90:79]);
			same("last_pixel", e.last, last);
			if (kind == RK_HEADER)
				n_headers++;
			else
				n_pixels++;
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               s_tuser = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_DW-1:0]  m_tdata;
	logic               m_tuser;
	logic               m_tlast;

	bmp_gray_scoreboard board;
	logic [7:0]         file_bytes[$];
	int                 src_mode = IDLE_NONE;
	int                 snk_mode = IDLE_NONE;
	int                 n_files = 0;

	bmp24_grayscale_stream_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// gap length: zero in IDLE_NONE, else often zero, some short, a few long
	function automatic int pick_gap(int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == IDLE_NONE)
			return 0;
		if (mode == IDLE_LIGHT) begin
			if (r < 80)
				return 0;
			if (r < 97)
				return $urandom_range(1, 3);
			return $urandom_range(8, 30);
		end
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [7:0] pix_byte(int style);
		if (style == PIX_ONES)
			return 8'hFF;
		if (style == PIX_EXTREME)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	// sink: random stalls on the result side
	initial begin : sink_drv
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				stall = pick_gap(snk_mode);
				m_tready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	// sample both sides at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_gray_beat(m_tdata, m_tuser, m_tlast);
			if (s_tvalid && s_tready)
				board.note_file_byte(s_tdata, s_tuser);
		end
	end

	// one byte beat; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic sof);
		int gap;
		gap = pick_gap(src_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= sof;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_file_bytes(input logic sof0, input int cut);
		int n;
		n = (cut > 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(file_bytes[i], (i == 0) ? sof0 : 1'b0);
		n_files++;
	endtask

	// build a file with the given header fields and send it, possibly cut short
	task automatic run_file(input logic [31:0] w, input logic [31:0] h, input logic [31:0] o,
			input logic sof0, input int cut, input int trail, input int style);
		int  cap;
		bit  valid;
		cap = (cut > 0) ? cut : (1 << 30);
		valid = (w != 0) && (h != 0) && (w <= MAX_WIDTH) && (h <= MAX_HEIGHT);
		file_bytes.delete();
		src_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
		snk_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
		for (int p = 0; p < HEADER_BYTES; p++) begin
			if (p >= OFFSET_POS && p < OFFSET_POS + 4)
				file_bytes.push_back(o[8*(p-OFFSET_POS) +: 8]);
			else if (p >= WIDTH_POS && p < WIDTH_POS + 4)
				file_bytes.push_back(w[8*(p-WIDTH_POS) +: 8]);
			else if (p >= HEIGHT_POS && p < HEIGHT_POS + 4)
				file_bytes.push_back(h[8*(p-HEIGHT_POS) +: 8]);
			else
				file_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if (valid) begin
			// gap between header and pixel data
			for (longint k = HEADER_BYTES; k < o && file_bytes.size() < cap; k++)
				file_bytes.push_back(8'($urandom_range(0, 255)));
			// bottom-up rows of bgr triples plus row padding
			for (int r = 0; r < h && file_bytes.size() < cap; r++) begin
				for (int c = 0; c < w && file_bytes.size() < cap; c++)
					repeat (3) file_bytes.push_back(pix_byte(style));
				repeat (w[1:0]) file_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (cut == 0)
			repeat (trail) file_bytes.push_back(8'($urandom_range(0, 255)));
		send_file_bytes(sof0, cut);
	endtask

	// run limit
	initial begin
		#5_000_000;
		$display("run timed out with %0d beats outstanding", board.expected_beats.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stim
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] o;
		logic [31:0] t;
		int          sel;
		int          stop_at;
		board = new;
		board.clear();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed: first file right after reset without a start flag, all-ones pixel
		run_file(1, 1, HEADER_BYTES, 1'b0, 0, 3, PIX_ONES);
		// offset inside the header, black and white pixels, three padding bytes
		run_file(3, 2, 0, 1'b1, 0, 0, PIX_EXTREME);
		// offset one below the header end, no padding
		run_file(4, 1, HEADER_BYTES - 1, 1'b1, 0, 1, PIX_EXTREME);
		// skip to offset, two padding bytes
		run_file(2, 2, 40, 1'b1, 0, 2, PIX_EXTREME);
		// zero height and zero width at the bound, trailing bytes ignored
		run_file(MAX_WIDTH, 0, HEADER_BYTES, 1'b1, 0, 3, PIX_RANDOM);
		run_file(0, MAX_HEIGHT, HEADER_BYTES, 1'b1, 0, 3, PIX_RANDOM);
		// too large: one over the bound, negative height, all fields saturated
		run_file(MAX_WIDTH + 1, 1, HEADER_BYTES, 1'b1, 0, 4, PIX_RANDOM);
		run_file(1, 32'hFFFF_FFFF, HEADER_BYTES, 1'b1, 0, 2, PIX_RANDOM);
		run_file(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0, 2, PIX_RANDOM);
		// largest legal image, restarted after a few pixels
		run_file(MAX_WIDTH, MAX_HEIGHT, HEADER_BYTES, 1'b1, HEADER_BYTES + 13, 0, PIX_RANDOM);
		// tall image restarted mid-pixels, high row numbers
		run_file(1, MAX_HEIGHT, HEADER_BYTES, 1'b1, HEADER_BYTES + 17, 0, PIX_RANDOM);
		// restart in the header and in the skip region
		run_file(5, 3, 36, 1'b1, 20, 0, PIX_RANDOM);
		run_file(2, 1, 32'h8000_0000, 1'b1, 50, 0, PIX_RANDOM);
		// wide single row
		run_file(70, 1, HEADER_BYTES + 1, 1'b1, 0, 1, PIX_RANDOM);

		// random files until enough bytes went in
		stop_at = board.n_bytes + RANDOM_BYTES;
		while (board.n_bytes < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				// well-formed small image, sometimes cut short
				w = $urandom_range(1, 7);
				h = $urandom_range(1, 4);
				if ($urandom_range(0, 9) < 8)
					o = HEADER_BYTES + $urandom_range(0, 8);
				else
					o = $urandom_range(0, HEADER_BYTES - 1);
				run_file(w, h, o, 1'b1,
					($urandom_range(0, 4) == 0) ? $urandom_range(1, 60) : 0,
					$urandom_range(0, 4),
					($urandom_range(0, 9) == 0) ? PIX_EXTREME : PIX_RANDOM);
			end else if (sel < 80) begin
				// zero width or height
				w = $urandom_range(0, 5000);
				h = 0;
				if ($urandom_range(0, 1)) begin
					t = w;
					w = h;
					h = t;
				end
				run_file(w, h, $urandom, 1'b1, 0, $urandom_range(0, 4), PIX_RANDOM);
			end else if (sel < 90) begin
				// oversized, random offset
				w = $urandom;
				if (w <= MAX_WIDTH)
					w = w + MAX_WIDTH + 1;
				h = $urandom_range(0, 10);
				if ($urandom_range(0, 1)) begin
					t = w;
					w = h;
					h = t;
				end
				run_file(w, h, $urandom, 1'b1, 0, $urandom_range(0, 4), PIX_RANDOM);
			end else begin
				// pure noise starting a new file
				file_bytes.delete();
				src_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
				snk_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
				repeat ($urandom_range(HEADER_BYTES, 60))
					file_bytes.push_back(8'($urandom_range(0, 255)));
				send_file_bytes(1'b1, 0);
			end
		end
		s_tvalid <= 1'b0;

		// drain, then let any stray beat show up
		snk_mode = IDLE_NONE;
		while (board.expected_beats.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d files in %0d bytes; checked %0d header beats and %0d pixel beats",
			n_files, board.n_bytes, board.n_headers, board.n_pixels);
		$display("covered oversize, zero size, short offsets, skips, padding and restarts");
		if (board.n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/bgs_pkg.sv
rtl/core/bgs_luma.sv
rtl/core/bgs_parse.sv
rtl/core/bmp24_grayscale_stream_core.sv
test/tb.sv
